### hdl/ggnh_pkg.sv
package ggnh_pkg;

  // Table geometry and field widths.
  localparam int MaxNodes     = 64;
  localparam int MaxNeighbors = 32;
  localparam int IdW          = 6;
  localparam int CoordW       = 16;
  localparam int SqW          = 2 * CoordW;
  localparam int DistW        = SqW + 1;
  localparam int LimitW       = 33;
  localparam int CntW         = $clog2(MaxNeighbors + 1);
  localparam int IdxW         = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;

  // Port widths.
  localparam int CfgIdxW  = 3;
  localparam int InDataW  = 40;
  localparam int OutDataW = 16;

  // Register reset values.
  localparam logic [CoordW-1:0] RadiusRst = CoordW'(80);
  localparam logic [LimitW-1:0] LimitRst  = LimitW'(2560000);

  // Request kinds carried on s_axis_tuser.
  localparam logic ReqOffer = 1'b0;
  localparam logic ReqRoute = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgSelfId  = 3'd0,
    CfgSelfX   = 3'd1,
    CfgSelfY   = 3'd2,
    CfgRadius  = 3'd3,
    CfgLimit   = 3'd4
  } cfg_reg_e;

  // One neighbor table entry.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } entry_t;

  // Side information carried alongside a distance through the pipeline.
  typedef struct packed {
    logic           live;
    logic [IdW-1:0] id;
  } tag_t;

endpackage

### hdl/ggnh_cell.sv
module ggnh_cell (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             shift_i,
  input  ggnh_pkg::entry_t load_data_i,
  input  ggnh_pkg::entry_t shift_data_i,
  output ggnh_pkg::entry_t entry_o
);

  ggnh_pkg::entry_t entry_q;
  ggnh_pkg::entry_t entry_d;

  // A new entry is written only while the ring is at rest.
  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = shift_data_i;
    end else if (load_i) begin
      entry_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### hdl/ggnh_dist.sv
module ggnh_dist (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  ggnh_pkg::tag_t                   tag_i,
  input  logic [ggnh_pkg::CoordW-1:0]      ax_i,
  input  logic [ggnh_pkg::CoordW-1:0]      ay_i,
  input  logic [ggnh_pkg::CoordW-1:0]      bx_i,
  input  logic [ggnh_pkg::CoordW-1:0]      by_i,
  output logic                             valid_o,
  output ggnh_pkg::tag_t                   tag_o,
  output logic [ggnh_pkg::DistW-1:0]       dist_o
);

  logic                          va_q, vb_q;
  ggnh_pkg::tag_t                taga_q, tagb_q;
  logic [ggnh_pkg::CoordW-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic [ggnh_pkg::SqW-1:0]      sqx_d, sqy_d, sqx_q, sqy_q;

  // First stage: absolute coordinate differences.
  assign dx_d = (ax_i > bx_i) ? (ax_i - bx_i) : (bx_i - ax_i);
  assign dy_d = (ay_i > by_i) ? (ay_i - by_i) : (by_i - ay_i);

  // Second stage: squares.
  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    taga_q <= tag_i;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    tagb_q <= taga_q;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
  end

  // The sum is exact in DistW bits.
  assign dist_o  = ggnh_pkg::DistW'(sqx_q) + ggnh_pkg::DistW'(sqy_q);
  assign valid_o = vb_q;
  assign tag_o   = tagb_q;

endmodule

### hdl/greedy_geographic_next_hop.sv
// Channel   Direction  Handshake                      Payload
// input     slave      s_axis_tvalid / s_axis_tready  tdata: node_id, pos_x, pos_y; tuser: req_type
// result    master     m_axis_tvalid / m_axis_tready  tdata: valid, hop id, added, full, count
// config    write      cfg_we_i                       cfg_idx_i selects, cfg_data_i carries value
//
// An offer waits in the offer wait state for its distance; its result is registered in the
// done state, after which the block returns to idle to take the next item. A route query's
// result is registered after the scan and drain states; in the scan the ring turns one
// entry per cycle past a single two-stage distance unit. Reset clears the entry count and
// the configuration registers to their defaults; table contents are not cleared.
// One item is in work at a time; a waiting result stalls the next item only at its last step.
module greedy_geographic_next_hop (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [ggnh_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ggnh_pkg::LimitW-1:0]         cfg_data_i,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // node_id [5:0], pos_x [21:6], pos_y [37:22], zero fill [39:38]
  input  logic [ggnh_pkg::InDataW-1:0]        s_axis_tdata,
  // req_type [0]
  input  logic                                s_axis_tuser,
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // next_hop_valid [0], next_hop_id [6:1], neighbor_added [7], table_full [8],
  // neighbor_count [14:9], zero fill [15]
  output logic [ggnh_pkg::OutDataW-1:0]       m_axis_tdata
);

  typedef enum logic [2:0] {
    StIdle,
    StOfferWait,
    StScan,
    StDrain,
    StDone
  } state_e;

  // Configuration registers.
  logic [ggnh_pkg::IdW-1:0]    self_id_q;
  logic [ggnh_pkg::CoordW-1:0] self_x_q, self_y_q, radius_q;
  logic [ggnh_pkg::LimitW-1:0] limit_q;
  logic [ggnh_pkg::SqW-1:0]    rsq_d, rsq_q;

  // Control and result registers.
  state_e                        state_q;
  logic [ggnh_pkg::CntW-1:0]     count_q;
  logic [ggnh_pkg::IdxW-1:0]     scan_idx_q;
  logic                          wait_q;
  logic [ggnh_pkg::DistW-1:0]    best_q;
  logic                          res_valid_q, res_added_q, res_full_q;
  logic [ggnh_pkg::IdW-1:0]      res_hop_q;
  logic                          m_valid_q;
  logic [ggnh_pkg::OutDataW-1:0] m_data_q;

  // Latched item fields.
  logic [ggnh_pkg::IdW-1:0]    req_id_q;
  logic [ggnh_pkg::CoordW-1:0] dest_x_q, dest_y_q;

  // Unpacked input fields.
  logic [ggnh_pkg::IdW-1:0]    in_id;
  logic [ggnh_pkg::CoordW-1:0] in_x, in_y;
  logic                        in_acc;

  // Distance unit connections.
  logic                        dist_vi, dist_vo;
  ggnh_pkg::tag_t              dist_ti, dist_to;
  logic [ggnh_pkg::CoordW-1:0] dist_ax, dist_ay, dist_bx, dist_by;
  logic [ggnh_pkg::DistW-1:0]  sq_dist;

  // Neighbor ring.
  ggnh_pkg::entry_t ring [ggnh_pkg::MaxNeighbors];
  ggnh_pkg::entry_t new_entry;
  logic             ring_shift;
  logic             ins_en;
  logic             in_range, room, better;

  assign in_id  = s_axis_tdata[5:0];
  assign in_x   = s_axis_tdata[21:6];
  assign in_y   = s_axis_tdata[37:22];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration writes land in their register directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q <= '0;
      self_x_q  <= '0;
      self_y_q  <= '0;
      radius_q  <= ggnh_pkg::RadiusRst;
      limit_q   <= ggnh_pkg::LimitRst;
    end else if (cfg_we_i) begin
      case (ggnh_pkg::cfg_reg_e'(cfg_idx_i))
        ggnh_pkg::CfgSelfId: self_id_q <= cfg_data_i[ggnh_pkg::IdW-1:0];
        ggnh_pkg::CfgSelfX:  self_x_q  <= cfg_data_i[ggnh_pkg::CoordW-1:0];
        ggnh_pkg::CfgSelfY:  self_y_q  <= cfg_data_i[ggnh_pkg::CoordW-1:0];
        ggnh_pkg::CfgRadius: radius_q  <= cfg_data_i[ggnh_pkg::CoordW-1:0];
        ggnh_pkg::CfgLimit:  limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The squared radius is registered from the radius register and follows it in the next cycle.
  // An offer compares against it at its decision; a radius written by its acceptance is used.
  assign rsq_d = radius_q * radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsq_q <= ggnh_pkg::SqW'(ggnh_pkg::RadiusRst * ggnh_pkg::RadiusRst);
    end else begin
      rsq_q <= rsq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_id_q <= in_id;
      dest_x_q <= in_x;
      dest_y_q <= in_y;
    end
  end

  // During a scan the distance unit sees the entry at the head of the ring;
  // on an offer it sees this node's position against the offered one.
  always_comb begin
    if (state_q == StScan) begin
      dist_vi      = 1'b1;
      dist_ax      = ring[0].x;
      dist_ay      = ring[0].y;
      dist_bx      = dest_x_q;
      dist_by      = dest_y_q;
      dist_ti.live = (ggnh_pkg::CntW'(scan_idx_q) < count_q);
      dist_ti.id   = ring[0].id;
    end else begin
      dist_vi      = in_acc && (s_axis_tuser == ggnh_pkg::ReqOffer);
      dist_ax      = self_x_q;
      dist_ay      = self_y_q;
      dist_bx      = in_x;
      dist_by      = in_y;
      dist_ti      = '0;
    end
  end

  ggnh_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_vi),
    .tag_i   (dist_ti),
    .ax_i    (dist_ax),
    .ay_i    (dist_ay),
    .bx_i    (dist_bx),
    .by_i    (dist_by),
    .valid_o (dist_vo),
    .tag_o   (dist_to),
    .dist_o  (sq_dist)
  );

  // Offer decision, taken in the offer wait state once wait_q is set and the distance is out.
  assign in_range = (req_id_q != self_id_q)
                 && (int'(req_id_q) < ggnh_pkg::MaxNodes)
                 && (sq_dist <= ggnh_pkg::DistW'(rsq_q));
  assign room     = (count_q < ggnh_pkg::CntW'(ggnh_pkg::MaxNeighbors));
  assign ins_en   = (state_q == StOfferWait) && wait_q && in_range && room;

  // Strict compare keeps the earliest entry on ties, since entries arrive in order.
  assign better   = dist_vo && dist_to.live && (sq_dist < best_q);

  assign new_entry.id = req_id_q;
  assign new_entry.x  = dest_x_q;
  assign new_entry.y  = dest_y_q;
  assign ring_shift   = (state_q == StScan);

  // The ring rotates toward cell zero once per scan cycle. A full scan makes
  // exactly one turn, so the table is back in its original order afterwards.
  for (genvar k = 0; k < ggnh_pkg::MaxNeighbors; k++) begin : g_cell
    ggnh_pkg::entry_t next_in;
    if (k == ggnh_pkg::MaxNeighbors - 1) begin : g_wrap
      assign next_in = ring[0];
    end else begin : g_link
      assign next_in = ring[k+1];
    end

    ggnh_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (ins_en && (count_q == ggnh_pkg::CntW'(k))),
      .shift_i      (ring_shift),
      .load_data_i  (new_entry),
      .shift_data_i (next_in),
      .entry_o      (ring[k])
    );
  end

  // Sequencer, result registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      scan_idx_q  <= '0;
      wait_q      <= 1'b0;
      best_q      <= '0;
      res_valid_q <= 1'b0;
      res_hop_q   <= '0;
      res_added_q <= 1'b0;
      res_full_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // In the last step the output register is refilled below instead.
      if (m_valid_q && m_axis_tready && (state_q != StDone)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_acc) begin
            res_valid_q <= 1'b0;
            res_hop_q   <= '0;
            res_added_q <= 1'b0;
            res_full_q  <= 1'b0;
            best_q      <= limit_q;
            scan_idx_q  <= '0;
            wait_q      <= 1'b0;
            state_q     <= (s_axis_tuser == ggnh_pkg::ReqRoute) ? StScan : StOfferWait;
          end
        end
        StOfferWait: begin
          if (wait_q) begin
            if (in_range) begin
              if (room) begin
                count_q     <= count_q + 1'b1;
                res_added_q <= 1'b1;
              end else begin
                res_full_q  <= 1'b1;
              end
            end
            state_q <= StDone;
          end
          wait_q <= 1'b1;
        end
        StScan: begin
          if (scan_idx_q == ggnh_pkg::IdxW'(ggnh_pkg::MaxNeighbors - 1)) begin
            wait_q  <= 1'b0;
            state_q <= StDrain;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        StDrain: begin
          // The drain ends once wait_q is set, letting the last entry leave the distance unit.
          if (wait_q) begin
            state_q <= StDone;
          end
          wait_q <= 1'b1;
        end
        StDone: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {1'b0, 6'(count_q), res_full_q, res_added_q,
                          res_hop_q, res_valid_q};
            m_valid_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      if (better) begin
        best_q      <= sq_dist;
        res_valid_q <= 1'b1;
        res_hop_q   <= dist_to.id;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### hdl/ggnh_chk.sv
module ggnh_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [ggnh_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input logic [ggnh_pkg::LimitW-1:0]       cfg_data_i,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [ggnh_pkg::InDataW-1:0]      s_axis_tdata,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ggnh_pkg::OutDataW-1:0]     m_axis_tdata
);

  // A stalled result keeps its valid and its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Without a chosen neighbor the hop id reads zero.
  a_hop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("hop id set without a valid next hop");

  // Route and offer flags never mix, and an offer is never both stored and dropped.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[7] && m_axis_tdata[8])
                   && !(m_axis_tdata[0] && (m_axis_tdata[7] || m_axis_tdata[8])))
    else $error("conflicting result flags");

  // The table never reports more entries than it holds.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:9] <= 6'(ggnh_pkg::MaxNeighbors))
    else $error("neighbor count out of range");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while one is in work");

endmodule

bind greedy_geographic_next_hop ggnh_chk u_ggnh_chk (.*);
